/* rtl/advest_pkg.sv */
// ----------------------------------------------------------------------------
// advest_pkg
// Shared types, constants and helpers for the advantage estimation scan.
// ----------------------------------------------------------------------------
package advest_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_GAMMA     = 2'd0,
    REG_LAMBDA    = 2'd1,
    REG_RECIP     = 2'd2,
    REG_NORMALIZE = 2'd3
  } advest_reg_e;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned FACTOR_W    = 17;
  localparam int unsigned GL_W        = 18;
  localparam int unsigned WORD_W      = 32;

  // Register reset values
  localparam logic [FACTOR_W-1:0] GAMMA_RST  = 17'd64881;
  localparam logic [FACTOR_W-1:0] LAMBDA_RST = 17'd62259;
  localparam logic [WORD_W-1:0]   RECIP_RST  = 32'd65536;

  // Normalized reward limits, +/-10.0 in Q16.16 at the floored product width
  localparam logic signed [47:0] CLAMP_HI = 48'sd655360;
  localparam logic signed [47:0] CLAMP_LO = -48'sd655360;

  // Front-to-back queue depth
  localparam int unsigned QUEUE_DEPTH = 2;

  // Classified step handed from front to back
  typedef struct packed {
    logic [WORD_W-1:0] delta;
    logic [WORD_W-1:0] reward;
    logic [WORD_W-1:0] value;
    logic              start;
    logic              sel_done;
    logic              sel_trunc;
  } advest_item_t;

  // Coefficients used by the recurrence
  typedef struct packed {
    logic [FACTOR_W-1:0] gamma;
    logic [GL_W-1:0]     gl;
  } advest_coef_t;

  // Saturate a 40-bit signed value into the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    logic signed [31:0] r;
    if (v[39:31] == 9'h000 || v[39:31] == 9'h1FF) begin
      r = v[31:0];
    end else if (v[39]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

/* rtl/advest_front.sv */
// ----------------------------------------------------------------------------
// advest_front
// Config registers, step intake, next-value/flag selection and delta compute.
// ----------------------------------------------------------------------------
module advest_front (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write channel
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [advest_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [advest_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // step input
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [31:0]                   reward_i,
  input  logic signed [31:0]                   value_estimate_i,
  input  logic                                 done_flag_i,
  input  logic                                 truncated_flag_i,
  input  logic                                 pass_start_i,
  input  logic signed [31:0]                   bootstrap_value_i,
  // toward queue
  output logic                                 push_valid_o,
  input  logic                                 push_ready_i,
  output advest_pkg::advest_item_t             item_o,
  output advest_pkg::advest_coef_t             coef_o
);
  import advest_pkg::*;

  // config registers
  logic [FACTOR_W-1:0] gamma_q, lambda_q;
  logic [WORD_W-1:0]   recip_q;
  logic                norm_q;
  logic [GL_W-1:0]     gl_q;
  logic [33:0]         gl_prod;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q  <= GAMMA_RST;
      lambda_q <= LAMBDA_RST;
      recip_q  <= RECIP_RST;
      norm_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (advest_reg_e'(cfg_index_i))
        REG_GAMMA:     gamma_q  <= cfg_data_i[FACTOR_W-1:0];
        REG_LAMBDA:    lambda_q <= cfg_data_i[FACTOR_W-1:0];
        REG_RECIP:     recip_q  <= cfg_data_i[WORD_W-1:0];
        REG_NORMALIZE: norm_q   <= cfg_data_i[0];
        default:       ;
      endcase
    end
  end

  // gamma*lambda each cycle; user must change config only while idle, unchecked
  assign gl_prod = gamma_q * lambda_q;

  always_ff @(posedge clk_i) begin
    gl_q <= gl_prod[33:16];
  end

  assign coef_o = '{gamma: gamma_q, gl: gl_q};

  // intake stage
  logic                a_vld_q, a_vld_d;
  logic                accept, a_adv;
  logic signed [31:0]  later_value_q;
  logic                later_done_q, later_trunc_q;
  logic signed [31:0]  next_value;
  logic signed [63:0]  rn_prod;
  logic signed [48:0]  gv_prod;
  logic signed [63:0]  a_rn_prod_q;
  logic signed [48:0]  a_gv_prod_q;
  logic signed [31:0]  a_reward_q, a_value_q;
  logic                a_start_q, a_done_q, a_trunc_q;

  assign a_adv      = a_vld_q & push_ready_i;
  assign in_stall_o = a_vld_q & ~push_ready_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign next_value = pass_start_i ? bootstrap_value_i : later_value_q;
  assign rn_prod    = reward_i * $signed({1'b0, recip_q});
  assign gv_prod    = next_value * $signed({1'b0, gamma_q});

  always_comb begin
    a_vld_d = a_vld_q;
    if (accept) begin
      a_vld_d = 1'b1;
    end else if (a_adv) begin
      a_vld_d = 1'b0;
    end
  end

  // control and carried step state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q       <= 1'b0;
      later_value_q <= '0;
      later_done_q  <= 1'b0;
      later_trunc_q <= 1'b0;
    end else begin
      a_vld_q <= a_vld_d;
      if (accept) begin
        later_value_q <= value_estimate_i;
        later_done_q  <= done_flag_i;
        later_trunc_q <= truncated_flag_i;
      end
    end
  end

  // intake payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_rn_prod_q <= rn_prod;
      a_gv_prod_q <= gv_prod;
      a_reward_q  <= reward_i;
      a_value_q   <= value_estimate_i;
      a_start_q   <= pass_start_i;
      a_done_q    <= pass_start_i ? done_flag_i      : later_done_q;
      a_trunc_q   <= pass_start_i ? truncated_flag_i : later_trunc_q;
    end
  end

  // reward normalization, prediction and delta
  logic signed [47:0] rn_full;
  logic signed [47:0] rn_clamped;
  logic signed [31:0] rn;
  logic signed [32:0] gv;
  logic signed [39:0] pred_sum;
  logic signed [31:0] pred;
  logic signed [31:0] delta;

  always_comb begin
    rn_full = a_rn_prod_q[63:16];
    if (rn_full > CLAMP_HI) begin
      rn_clamped = CLAMP_HI;
    end else if (rn_full < CLAMP_LO) begin
      rn_clamped = CLAMP_LO;
    end else begin
      rn_clamped = rn_full;
    end
    rn = norm_q ? rn_clamped[31:0] : a_reward_q;
    gv = a_gv_prod_q[48:16];
    pred_sum = {{8{rn[31]}}, rn};
    if (!a_done_q) begin
      pred_sum = pred_sum + {{7{gv[32]}}, gv};
    end
    pred  = sat32(pred_sum);
    delta = sat32({{8{pred[31]}}, pred} - {{8{a_value_q[31]}}, a_value_q});
  end

  assign push_valid_o = a_vld_q;
  assign item_o = '{delta:     delta,
                    reward:    a_reward_q,
                    value:     a_value_q,
                    start:     a_start_q,
                    sel_done:  a_done_q,
                    sel_trunc: a_trunc_q};

endmodule

/* rtl/advest_queue.sv */
// ----------------------------------------------------------------------------
// advest_queue
// Small register FIFO that decouples the front from the back.
// ----------------------------------------------------------------------------
module advest_queue #(
  parameter int unsigned Depth = advest_pkg::QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  output logic                     push_ready_o,
  input  advest_pkg::advest_item_t push_item_i,
  output logic                     pop_valid_o,
  input  logic                     pop_i,
  output advest_pkg::advest_item_t pop_item_o
);
  import advest_pkg::*;

  // a single-entry queue still keeps a one-bit pointer
  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  advest_item_t        mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     count_q;
  logic                do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_i & pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef ASSERT_OFF
  // fill count stays within depth
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count above depth");

  // back never pops an empty queue
  a_no_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> pop_valid_o)
    else $error("pop from empty queue");

  // a lone push grows the count by one
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("count did not follow push");

  // a lone pop shrinks the count by one
  a_pop_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_pop && !do_push) |=> count_q == $past(count_q) - 1'b1)
    else $error("count did not follow pop");
`endif

endmodule

/* rtl/advest_back.sv */
// ----------------------------------------------------------------------------
// advest_back
// Advantage and return recurrence, value target and output register.
// ----------------------------------------------------------------------------
module advest_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     pop_valid_i,
  output logic                     pop_o,
  input  advest_pkg::advest_item_t item_i,
  input  advest_pkg::advest_coef_t coef_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [31:0]       advantage_o,
  output logic signed [31:0]       discounted_return_o,
  output logic signed [31:0]       value_target_o
);
  import advest_pkg::*;

  logic               e_vld_q, e_vld_d;
  logic               o_vld_q, o_vld_d;
  logic               o_free, e_move, out_take;
  logic signed [31:0] run_adv_q, run_ret_q, e_value_q;
  logic signed [31:0] o_adv_q, o_ret_q, o_vt_q;

  assign o_free   = ~o_vld_q | ~out_stall_i;
  assign e_move   = e_vld_q & o_free;
  assign pop_o    = pop_valid_i & (~e_vld_q | e_move);
  assign out_take = o_vld_q & ~out_stall_i;

  // recurrence step; a pass start clears the accumulators
  logic signed [31:0] adv_in, ret_in;
  logic signed [50:0] adv_prod;
  logic signed [48:0] ret_prod;
  logic signed [34:0] adv_term;
  logic signed [32:0] ret_term;
  logic signed [31:0] delta, reward;
  logic signed [31:0] adv_new, ret_new;

  always_comb begin
    delta    = item_i.delta;
    reward   = item_i.reward;
    adv_in   = item_i.start ? '0 : run_adv_q;
    ret_in   = item_i.start ? '0 : run_ret_q;
    adv_prod = adv_in * $signed({1'b0, coef_i.gl});
    ret_prod = ret_in * $signed({1'b0, coef_i.gamma});
    adv_term = item_i.sel_done ? '0 : adv_prod[50:16];
    ret_term = (item_i.sel_done || item_i.sel_trunc) ? '0 : ret_prod[48:16];
    adv_new  = sat32({{8{delta[31]}}, delta} + {{5{adv_term[34]}}, adv_term});
    ret_new  = sat32({{8{reward[31]}}, reward} + {{7{ret_term[32]}}, ret_term});
  end

  always_comb begin
    e_vld_d = e_vld_q;
    if (pop_o) begin
      e_vld_d = 1'b1;
    end else if (e_move) begin
      e_vld_d = 1'b0;
    end
    o_vld_d = o_vld_q;
    if (e_move) begin
      o_vld_d = 1'b1;
    end else if (out_take) begin
      o_vld_d = 1'b0;
    end
  end

  // valid bits and running accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q   <= 1'b0;
      o_vld_q   <= 1'b0;
      run_adv_q <= '0;
      run_ret_q <= '0;
    end else begin
      e_vld_q <= e_vld_d;
      o_vld_q <= o_vld_d;
      if (pop_o) begin
        run_adv_q <= adv_new;
        run_ret_q <= ret_new;
      end
    end
  end

  // value carried alongside, and the output word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      e_value_q <= item_i.value;
    end
    if (e_move) begin
      o_adv_q <= run_adv_q;
      o_ret_q <= run_ret_q;
      o_vt_q  <= sat32({{8{e_value_q[31]}}, e_value_q} + {{8{run_adv_q[31]}}, run_adv_q});
    end
  end

  assign out_valid_o         = o_vld_q;
  assign advantage_o         = o_adv_q;
  assign discounted_return_o = o_ret_q;
  assign value_target_o      = o_vt_q;

`ifndef ASSERT_OFF
  // a word moves out of the recurrence only into a free output slot
  a_move_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_move |-> (!o_vld_q || !out_stall_i))
    else $error("recurrence overwrote a held output word");

  // a stalled output word keeps its value target
  a_hold_vt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && out_stall_i) |=> $stable(o_vt_q))
    else $error("held output word changed");

  // accumulators only change when a step is popped
  a_acc_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pop_o |=> ($stable(run_adv_q) && $stable(run_ret_q)))
    else $error("accumulator changed without a step");
`endif

endmodule

/* rtl/advantage_estimation_scan.sv */
// Steps pass the intake registers, a queue entry, the accumulators and the output register.
// Throughput: one step per cycle when not stalled; the advantage/return recurrence
// is a single multiply-add-saturate through the back end's accumulator registers.
// Reset: config registers return to defaults, accumulators and carried step state
// clear to zero; no clearing pass, steps are taken right after reset.
// ----------------------------------------------------------------------------
// advantage_estimation_scan
// Generalized advantage estimation over reverse-ordered trajectory steps,
// signed Q16.16 with saturation; front end, queue and recurrence back end.
// ----------------------------------------------------------------------------
module advantage_estimation_scan #(
  parameter int unsigned QueueDepth = advest_pkg::QUEUE_DEPTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [advest_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [advest_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [31:0]                 reward_i,
  input  logic signed [31:0]                 value_estimate_i,
  input  logic                               done_flag_i,
  input  logic                               truncated_flag_i,
  input  logic                               pass_start_i,
  input  logic signed [31:0]                 bootstrap_value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [31:0]                 advantage_o,
  output logic signed [31:0]                 discounted_return_o,
  output logic signed [31:0]                 value_target_o
);
  import advest_pkg::*;

  logic         push_valid, push_ready;
  logic         pop_valid, pop;
  advest_item_t push_item, pop_item;
  advest_coef_t coef;

  advest_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .reward_i          (reward_i),
    .value_estimate_i  (value_estimate_i),
    .done_flag_i       (done_flag_i),
    .truncated_flag_i  (truncated_flag_i),
    .pass_start_i      (pass_start_i),
    .bootstrap_value_i (bootstrap_value_i),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .item_o            (push_item),
    .coef_o            (coef)
  );

  advest_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .pop_item_o   (pop_item)
  );

  advest_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .pop_valid_i         (pop_valid),
    .pop_o               (pop),
    .item_i              (pop_item),
    .coef_i              (coef),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .advantage_o         (advantage_o),
    .discounted_return_o (discounted_return_o),
    .value_target_o      (value_target_o)
  );

endmodule

/* tb/sv/advantage_estimation_scan_checker.sv */
// ----------------------------------------------------------------------------
// advantage_estimation_scan_checker
// Watches the config, step and result channels of the advantage estimation
// scan. Keeps its own copy of the registers and the recurrence state, predicts
// advantage, discounted return and value target for every accepted step word,
// and compares each accepted result word against the oldest prediction.
// ----------------------------------------------------------------------------
module advantage_estimation_scan_checker
  import advest_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic signed [31:0]       reward_i,
  input  logic signed [31:0]       value_estimate_i,
  input  logic                     done_flag_i,
  input  logic                     truncated_flag_i,
  input  logic                     pass_start_i,
  input  logic signed [31:0]       bootstrap_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [31:0]       advantage_i,
  input  logic signed [31:0]       discounted_return_i,
  input  logic signed [31:0]       value_target_i,
  output int                       error_count_o,
  output int                       waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint REWARD_LIMIT = 64'sd655360;  // 10.0 in Q16.16

  typedef struct packed {
    logic signed [31:0] advantage;
    logic signed [31:0] discounted_return;
    logic signed [31:0] value_target;
  } estimate_t;

  // Register copy
  logic [FACTOR_W-1:0] gamma_q;
  logic [FACTOR_W-1:0] lambda_q;
  logic [WORD_W-1:0]   recip_q;
  logic                norm_q;

  // Recurrence state, carried between step words
  longint run_adv;
  longint run_ret;
  longint later_value;
  logic   later_done;
  logic   later_trunc;

  estimate_t estimates_q[$];
  int        mismatches;

  assign error_count_o = mismatches;

  function automatic longint clip_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // One step of the reverse scan; updates the carried state
  function automatic estimate_t estimate_step(
    input logic signed [31:0] reward,
    input logic signed [31:0] value,
    input logic               done,
    input logic               trunc,
    input logic               start,
    input logic signed [31:0] boot
  );
    longint    rwd, val, nxt, rn, pred, delta, gl, adv, ret, gam, lam, rcp;
    logic      sel_done, sel_trunc;
    estimate_t est;
    rwd = longint'(reward);
    val = longint'(value);
    gam = longint'(gamma_q);
    lam = longint'(lambda_q);
    rcp = longint'(recip_q);
    if (start) begin
      run_adv   = 0;
      run_ret   = 0;
      nxt       = longint'(boot);
      sel_done  = done;
      sel_trunc = trunc;
    end else begin
      nxt       = later_value;
      sel_done  = later_done;
      sel_trunc = later_trunc;
    end
    // reward normalization: scale, floor, clamp to +/-10
    if (norm_q) begin
      rn = (rwd * rcp) >>> 16;
      if (rn > REWARD_LIMIT) rn = REWARD_LIMIT;
      if (rn < -REWARD_LIMIT) rn = -REWARD_LIMIT;
    end else begin
      rn = rwd;
    end
    pred = rn;
    if (!sel_done) pred += (gam * nxt) >>> 16;
    pred  = clip_word(pred);
    delta = clip_word(pred - val);
    gl  = (gam * lam) >>> 16;
    adv = delta;
    if (!sel_done) adv += (gl * run_adv) >>> 16;
    adv = clip_word(adv);
    ret = rwd;
    if (!sel_done && !sel_trunc) ret += (run_ret * gam) >>> 16;
    ret = clip_word(ret);
    run_adv     = adv;
    run_ret     = ret;
    later_value = val;
    later_done  = done;
    later_trunc = trunc;
    est.advantage         = adv[31:0];
    est.discounted_return = ret[31:0];
    est.value_target      = 32'(clip_word(val + adv));
    return est;
  endfunction

  task automatic check_word(input string name, input logic signed [31:0] want,
                            input logic signed [31:0] got);
    if (got !== want) begin
      mismatches++;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  // Track all three channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin : track
    estimate_t want;
    if (!rst_ni) begin
      gamma_q     = GAMMA_RST;
      lambda_q    = LAMBDA_RST;
      recip_q     = RECIP_RST;
      norm_q      = 1'b0;
      run_adv     = 0;
      run_ret     = 0;
      later_value = 0;
      later_done  = 1'b0;
      later_trunc = 1'b0;
      mismatches  = 0;
      estimates_q.delete();
      waiting_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_GAMMA:     gamma_q  = cfg_data_i[FACTOR_W-1:0];
          REG_LAMBDA:    lambda_q = cfg_data_i[FACTOR_W-1:0];
          REG_RECIP:     recip_q  = cfg_data_i;
          REG_NORMALIZE: norm_q   = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        estimates_q.push_back(estimate_step(reward_i, value_estimate_i, done_flag_i,
                                            truncated_flag_i, pass_start_i,
                                            bootstrap_value_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (estimates_q.size() == 0) begin
          mismatches++;
          $error("result word with no step pending: advantage %0d", advantage_i);
        end else begin
          want = estimates_q.pop_front();
          check_word("advantage", want.advantage, advantage_i);
          check_word("discounted_return", want.discounted_return, discounted_return_i);
          check_word("value_target", want.value_target, value_target_i);
        end
      end
      waiting_o = estimates_q.size();
    end
  end

endmodule

/* tb/sv/advantage_estimation_scan_test.sv */
// ----------------------------------------------------------------------------
// advantage_estimation_scan_test
// Drives register settings and reverse-ordered trajectory steps into the
// advantage estimation scan with random idling on both channels, a long
// output hold-off and a full drain, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module advantage_estimation_scan_test;
  import advest_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLACK_CYCLES  = 8;
  localparam int HOLD_CYCLES   = 150;
  localparam int PHASE_STEPS   = 140;
  localparam int NUM_PHASES    = 8;

  typedef struct packed {
    logic signed [31:0] reward;
    logic signed [31:0] value;
    logic               done;
    logic               trunc;
    logic               start;
    logic signed [31:0] boot;
  } step_t;

  // Directed steps: reward, value, done, truncated, pass start, bootstrap
  localparam step_t DIRECTED[24] = '{
    // no pass opened yet, continues from reset state
    '{32'h0001_0000, 32'h0000_8000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{32'h0002_0000, 32'hFFFF_0000, 1'b0, 1'b0, 1'b0, 32'h7FFF_FFFF},
    // saturating extremes
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b0, 1'b0, 32'h0},
    '{32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{32'h0003_0000, 32'h0000_4000, 1'b0, 1'b1, 1'b0, 32'h0},
    '{32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
    // pass start with its own flags
    '{32'h0001_0000, 32'h0002_0000, 1'b1, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'h0001_0000, 32'h0002_0000, 1'b0, 1'b1, 1'b1, 32'h8000_0000},
    '{32'hFFFF_0000, 32'h0002_0000, 1'b1, 1'b1, 1'b1, 32'h0005_0000},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h8000_0000},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 1'b1, 32'h8000_0000},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b1, 1'b0, 32'h5555_5555},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, 1'b0, 32'hAAAA_AAAA},
    // normalization on, zero reciprocal, factors above one
    '{32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h0001_0000, 1'b0, 1'b0, 1'b0, 32'h0},
    // normalization on, largest reciprocal: both clamp limits
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 1'b1, 32'h7FFF_FFFF},
    '{32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0},
    // zero factors
    '{32'h0001_0000, 32'h0000_8000, 1'b0, 1'b0, 1'b1, 32'h0004_0000},
    '{32'h0002_0000, 32'h0000_8000, 1'b0, 1'b0, 1'b0, 32'h0}
  };

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic signed [31:0]     reward_i;
  logic signed [31:0]     value_estimate_i;
  logic                   done_flag_i;
  logic                   truncated_flag_i;
  logic                   pass_start_i;
  logic signed [31:0]     bootstrap_value_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic signed [31:0]     advantage_o;
  logic signed [31:0]     discounted_return_o;
  logic signed [31:0]     value_target_o;

  int errors;
  int queued;
  bit quiet;      // no idling on either side
  bit hold_req;   // asks the result side for a long hold-off

  advantage_estimation_scan u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o,
    .reward_i, .value_estimate_i, .done_flag_i, .truncated_flag_i,
    .pass_start_i, .bootstrap_value_i,
    .out_valid_o, .out_stall_i,
    .advantage_o, .discounted_return_o, .value_target_o
  );

  advantage_estimation_scan_checker u_check (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o),
    .reward_i, .value_estimate_i, .done_flag_i, .truncated_flag_i,
    .pass_start_i, .bootstrap_value_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .advantage_i(advantage_o), .discounted_return_i(discounted_return_o),
    .value_target_i(value_target_o),
    .error_count_o(errors), .waiting_o(queued)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stalls, or a long counted hold-off on request
  initial begin : result_side
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= !quiet && ($urandom_range(0, 99) < 23);
      end
    end
  end

  // Q16.16 word: mostly moderate, sometimes full range or an extreme
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      1, 2: return $urandom;
      default: return 32'(int'($urandom_range(0, 2621440)) - 1310720);
    endcase
  endfunction

  function automatic step_t random_step(input bit opens);
    step_t s;
    s.reward = pick_word();
    s.value  = pick_word();
    s.boot   = pick_word();
    s.start  = opens;
    s.done   = $urandom_range(0, 99) < (opens ? 30 : 6);
    s.trunc  = $urandom_range(0, 99) < (opens ? 30 : 6);
    return s;
  endfunction

  // Present one step word and hold it until taken; called at a clock edge
  task automatic send_step(input step_t s);
    in_valid_i        <= 1'b1;
    reward_i          <= s.reward;
    value_estimate_i  <= s.value;
    done_flag_i       <= s.done;
    truncated_flag_i  <= s.trunc;
    pass_start_i      <= s.start;
    bootstrap_value_i <= s.boot;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_gap();
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every predicted result has come back;
  // let a clock edge pass first so the count already holds the last accepted step
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (queued != 0) @(posedge clk_i);
    repeat (SLACK_CYCLES) @(posedge clk_i);
  endtask

  // Write all four registers back to back; only while the block is idle
  task automatic load_settings(input logic [FACTOR_W-1:0] g, input logic [FACTOR_W-1:0] l,
                               input logic [WORD_W-1:0] r, input logic n);
    advest_reg_e  regs[4];
    logic [31:0]  vals[4];
    logic [31:0]  junk;
    junk = $urandom;
    regs = '{REG_GAMMA, REG_LAMBDA, REG_RECIP, REG_NORMALIZE};
    // unused upper data bits carry noise
    vals = '{{junk[31:FACTOR_W], g}, {~junk[31:FACTOR_W], l}, r, {junk[31:1], n}};
    cfg_valid_i <= 1'b1;
    foreach (regs[i]) begin
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_list(input int lo, input int hi);
    for (int i = lo; i <= hi; i++) begin
      send_step(DIRECTED[i]);
      idle_gap();
    end
  endtask

  // Trajectories of random length, a few without an opening step
  task automatic run_random_steps(input int count, input bit with_pressure);
    int  sent;
    int  len;
    bit  broken;
    sent = 0;
    while (sent < count) begin
      len    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      broken = ($urandom_range(0, 7) == 0);
      for (int k = 0; k < len && sent < count; k++) begin
        if (with_pressure && sent == count / 3) hold_req = 1'b1;
        send_step(random_step(k == 0 && !broken));
        sent++;
        idle_gap();
        if (with_pressure && sent == count / 2) wait_drained();
      end
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [WORD_W-1:0] recip;
    quiet             = 1'b0;
    hold_req          = 1'b0;
    rst_ni            <= 1'b0;
    cfg_valid_i       <= 1'b0;
    cfg_index_i       <= '0;
    cfg_data_i        <= '0;
    in_valid_i        <= 1'b0;
    reward_i          <= '0;
    value_estimate_i  <= '0;
    done_flag_i       <= 1'b0;
    truncated_flag_i  <= 1'b0;
    pass_start_i      <= 1'b0;
    bootstrap_value_i <= '0;
    out_stall_i       <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset settings first
    send_list(0, 15);
    wait_drained();
    load_settings(17'h1FFFF, 17'h1FFFF, 32'h0, 1'b1);
    send_list(16, 17);
    wait_drained();
    load_settings(17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1);
    send_list(18, 21);
    wait_drained();
    load_settings(17'd0, 17'd0, RECIP_RST, 1'b0);
    send_list(22, 23);
    wait_drained();

    // random part, one register setting per phase
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: load_settings(GAMMA_RST, LAMBDA_RST, RECIP_RST, 1'b0);
        1: load_settings(17'd65536, 17'd65536, 32'h0001_0000, 1'b1);
        2: load_settings(17'd0, 17'd0, 32'h0, 1'b1);
        3: load_settings(17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 1'b1);
        4: load_settings(17'd65536, 17'd0, 32'h0002_0000, 1'b0);
        default: begin
          recip = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
          load_settings(FACTOR_W'($urandom_range(0, 131071)),
                        FACTOR_W'($urandom_range(0, 131071)), recip,
                        1'($urandom_range(0, 1)));
        end
      endcase
      quiet = (phase == 4);
      run_random_steps(PHASE_STEPS, phase == 2);
      wait_drained();
      quiet = 1'b0;
    end

    if (queued != 0) $error("%0d result words never arrived", queued);
    if (errors == 0 && queued == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/advest_pkg.sv
rtl/advest_front.sv
rtl/advest_queue.sv
rtl/advest_back.sv
rtl/advantage_estimation_scan.sv
tb/sv/advantage_estimation_scan_checker.sv
tb/sv/advantage_estimation_scan_test.sv
